/* hdl/indexed_shift_list_macros.svh */
// ----------------------------------------------------------------------------
// indexed_shift_list_macros
// assertion macros used by the checker file of the shift list
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_MACROS_SVH
`define INDEXED_SHIFT_LIST_MACROS_SVH

// property must hold at every clock edge outside reset
`define ISL_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ISL_ASSERT_NEVER(label, clock, reset, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* hdl/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg
// types and constants of the indexed shift list
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // wide enough for any index or count up to the largest capacity (256)
  localparam int CTL_IDX_W = 9;

  // command codes
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // operation broadcast to the cell row
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_INSERT = 2'd3
  } cell_op_t;

  // command transaction
  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  position;
    logic [31:0] write_value;
  } request_t;

  // result transaction
  typedef struct packed {
    logic [31:0] read_value;
    status_t     status;
    logic [4:0]  count_after;
  } result_t;

  // control broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t               op;
    logic [CTL_IDX_W-1:0]   pos;
    logic [CTL_IDX_W-1:0]   count;
    logic                   rd_en;
    logic [CTL_IDX_W-1:0]   rd_idx;
  } cell_ctl_t;

  // status and length that travel beside the read gather
  typedef struct packed {
    status_t    status;
    logic [4:0] count_after;
  } meta_t;

endpackage

/* hdl/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell
// one entry of the list: holds a word, shifts with its neighbors
// ----------------------------------------------------------------------------
module isl_cell import isl_pkg::*; #(
  parameter int INDEX         = 0,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [ELEMENT_WIDTH-1:0] wval,
  input  logic [ELEMENT_WIDTH-1:0] up_data,
  input  logic [ELEMENT_WIDTH-1:0] down_data,
  output logic [ELEMENT_WIDTH-1:0] data,
  output logic [ELEMENT_WIDTH-1:0] tap
);

  localparam logic [CTL_IDX_W-1:0] IDX  = CTL_IDX_W'(INDEX);
  localparam logic [CTL_IDX_W-1:0] IDX1 = CTL_IDX_W'(INDEX + 1);

  logic [ELEMENT_WIDTH-1:0] data_next;

  // next word from the broadcast operation and this cell's position
  always_comb begin
    data_next = data;
    case (ctl.op)
      OP_PUSH: begin
        if (IDX == ctl.count) data_next = wval;
      end
      OP_REMOVE: begin
        // close the gap: cells from pos up take their upper neighbor
        if (IDX >= ctl.pos && IDX1 < ctl.count) data_next = up_data;
      end
      OP_INSERT: begin
        // open a slot at pos: cells above it take their lower neighbor
        if (IDX == ctl.pos) begin
          data_next = wval;
        end else if (IDX > ctl.pos && IDX <= ctl.count) begin
          data_next = down_data;
        end
      end
      default: data_next = data;
    endcase
  end

  // entry storage, undefined until written
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // read tap: the old word when this cell is the one being read
  assign tap = (ctl.rd_en && ctl.rd_idx == IDX) ? data : '0;

endmodule

/* hdl/isl_ctrl.sv */
// ----------------------------------------------------------------------------
// isl_ctrl
// command decode, length register and cell row control
// ----------------------------------------------------------------------------
module isl_ctrl import isl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  cmd_t       cmd,
  input  logic [3:0] position,
  output cell_ctl_t  ctl,
  output meta_t      meta
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;
  logic [CMPW-1:0] pos_c;
  logic            full;
  logic            empty;
  logic            in_range;
  status_t         status;

  assign pos_c    = CMPW'(position);
  assign full     = (cnt == CW'(CAPACITY));
  assign empty    = (cnt == '0);
  assign in_range = (pos_c < CMPW'(cnt));

  // decode of the accepted command
  always_comb begin
    cnt_next   = cnt;
    status     = ST_OK;
    ctl.op     = OP_HOLD;
    ctl.pos    = CTL_IDX_W'(pos_c);
    ctl.count  = CTL_IDX_W'(cnt);
    ctl.rd_en  = 1'b0;
    ctl.rd_idx = CTL_IDX_W'(pos_c);
    if (accept) begin
      unique case (cmd)
        CMD_PUSH: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctl.op   = OP_PUSH;
            cnt_next = cnt + CW'(1);
          end
        end
        CMD_POP: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_idx = CTL_IDX_W'(cnt - CW'(1));
            cnt_next   = cnt - CW'(1);
          end
        end
        CMD_REMOVE: begin
          if (empty) begin
            status = ST_EMPTY;
          end else if (!in_range) begin
            status = ST_RANGE;
          end else begin
            ctl.op    = OP_REMOVE;
            ctl.rd_en = 1'b1;
            cnt_next  = cnt - CW'(1);
          end
        end
        CMD_INSERT: begin
          // index is checked before fullness
          if (!in_range) begin
            status = ST_RANGE;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            ctl.op   = OP_INSERT;
            cnt_next = cnt + CW'(1);
          end
        end
        CMD_CLEAR: cnt_next = '0;
        default:   cnt_next = cnt;
      endcase
    end
  end

  assign meta.status      = status;
  assign meta.count_after = 5'(cnt_next);

  // list length
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

/* hdl/isl_gather.sv */
// ----------------------------------------------------------------------------
// isl_gather
// two-level registered or-tree that collects the read taps of the cell row
// ----------------------------------------------------------------------------
module isl_gather import isl_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic [CAPACITY-1:0][ELEMENT_WIDTH-1:0] taps,
  output logic [ELEMENT_WIDTH-1:0]               data
);

  localparam int GROUP = 16;
  localparam int NG    = (CAPACITY + GROUP - 1) / GROUP;

  logic [NG-1:0][ELEMENT_WIDTH-1:0] grp;
  logic [NG-1:0][ELEMENT_WIDTH-1:0] grp_next;
  logic [ELEMENT_WIDTH-1:0]         data_next;

  // first level: or within each group of cells
  always_comb begin
    grp_next = '0;
    for (int g = 0; g < NG; g++) begin
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < CAPACITY) grp_next[g] = grp_next[g] | taps[g * GROUP + j];
      end
    end
  end

  // second level: or across the group registers
  always_comb begin
    data_next = '0;
    for (int g = 0; g < NG; g++) begin
      data_next = data_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    grp  <= grp_next;
    data <= data_next;
  end

endmodule

/* hdl/indexed_shift_list.sv */
// ----------------------------------------------------------------------------
// indexed_shift_list
// ordered list with push, pop, remove-at, insert-at and clear
// ----------------------------------------------------------------------------
// One command is taken in every clock cycle: busy stays low, and a command is
// a transaction whenever start is high. Each command produces one result
// transaction, strobed on done for a single cycle once its valid flag has
// passed valid1 and valid2; the receiver cannot stall, so results must be
// captured when done is high. The rate is set by the row of cells, which all
// shift or load in parallel in the cycle the command is taken; the result
// delay comes from the registered or-tree that gathers the word read by a
// pop or remove-at. Failed commands leave the list unchanged and return a
// zero read value. Entries are stored at ELEMENT_WIDTH bits; write values are
// truncated or zero-extended to that width and read values to 32 bits.
// ----------------------------------------------------------------------------
module indexed_shift_list import isl_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int XW = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;

  logic                                   accept;
  cell_ctl_t                              ctl;
  meta_t                                  meta;
  meta_t                                  meta1;
  meta_t                                  meta2;
  logic                                   valid1;
  logic                                   valid2;
  logic [XW-1:0]                          wval_wide;
  logic [ELEMENT_WIDTH-1:0]               wval;
  logic [CAPACITY-1:0][ELEMENT_WIDTH-1:0] cell_data;
  logic [CAPACITY-1:0][ELEMENT_WIDTH-1:0] cell_tap;
  logic [ELEMENT_WIDTH-1:0]               rd_data;
  logic [XW-1:0]                          rd_wide;

  // every command completes its state update in the cycle it is taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // write value fitted to the element width
  assign wval_wide = XW'(request.write_value);
  assign wval      = wval_wide[ELEMENT_WIDTH-1:0];

  // command decode and length
  isl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (request.cmd),
    .position (request.position),
    .ctl      (ctl),
    .meta     (meta)
  );

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] up_data;
    logic [ELEMENT_WIDTH-1:0] down_data;

    if (i == CAPACITY - 1) begin : g_top
      assign up_data = '0;
    end else begin : g_mid_up
      assign up_data = cell_data[i + 1];
    end

    if (i == 0) begin : g_bottom
      assign down_data = '0;
    end else begin : g_mid_down
      assign down_data = cell_data[i - 1];
    end

    isl_cell #(
      .INDEX         (i),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wval      (wval),
      .up_data   (up_data),
      .down_data (down_data),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  // read word gather
  isl_gather #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_gather (
    .clk  (clk),
    .taps (cell_tap),
    .data (rd_data)
  );

  // status and length follow the gather latency
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= accept;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    meta1 <= meta;
    meta2 <= meta1;
  end

  // result transaction
  assign rd_wide            = XW'(rd_data);
  assign done               = valid2;
  assign result.read_value  = rd_wide[31:0];
  assign result.status      = meta2.status;
  assign result.count_after = meta2.count_after;

endmodule

/* hdl/isl_checker.sv */
// ----------------------------------------------------------------------------
// isl_checker
// port-level checks of the shift list, bound to the top level
// ----------------------------------------------------------------------------
`include "indexed_shift_list_macros.svh"

module isl_checker import isl_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  logic [4:0] last_count;
  logic       taken;
  logic       failed;
  logic       fail_clean;
  logic       step_ok;
  logic       empty_with_len;

  // length reported by the most recent result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (done) begin
      last_count <= result.count_after;
    end
  end

  // conditions seen on the ports
  assign taken          = start && !busy;
  assign failed         = done && (result.status != ST_OK);
  assign fail_clean     = (result.count_after == last_count) &&
                          (result.read_value == 32'd0);
  assign step_ok        = (result.count_after == last_count) ||
                          (result.count_after == 5'(last_count + 5'd1)) ||
                          (result.count_after == 5'(last_count - 5'd1)) ||
                          (result.count_after == 5'd0);
  assign empty_with_len = done && (result.status == ST_EMPTY) &&
                          (result.count_after != 5'd0);

  // every transaction is answered by a done strobe
  `ISL_ASSERT_CLK(a_answer, clk, rst, taken |-> ##2 done, "command without result")

  // no result without an earlier transaction
  `ISL_ASSERT_CLK(a_no_extra, clk, rst, done |-> $past(taken, 2), "result without command")

  // a failed command leaves the length unchanged and reads zero
  `ISL_ASSERT_CLK(a_fail_hold, clk, rst, failed |-> fail_clean, "failed command changed list")

  // length moves by at most one, or drops to zero on clear
  `ISL_ASSERT_CLK(a_step, clk, rst, done |-> step_ok, "length jumped")

  // an empty report comes only with a zero length
  `ISL_ASSERT_NEVER(a_empty_len, clk, rst, empty_with_len, "empty status with entries")

endmodule

bind indexed_shift_list isl_checker u_checker (.*);
